// ----- src/b64lw_pkg.sv -----
// Shared types, constants and the alphabet lookup for the base64 line-wrap encoder.
// No dependencies; imported by the front, back, top, checker and testbench.
package b64lw_pkg;

  localparam logic [7:0] LINE_CHARS_RST = 8'd76;
  localparam logic [7:0] CHAR_PAD       = 8'h3D;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [2:0] IDX_CR         = 3'd4;
  localparam logic [2:0] IDX_LF         = 3'd5;

  // One encoded group: four characters, first in chars[0], and a line-break flag
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            crlf;
  } job_t;

  // Map a 6-bit value to the standard base64 alphabet
  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    logic [7:0] r;
    priority if (v < 6'd26) begin
      r = 8'(8'h41 + {2'b00, v});
    end else if (v < 6'd52) begin
      r = 8'(8'h61 + {2'b00, v} - 8'd26);
    end else if (v < 6'd62) begin
      r = 8'(8'h30 + {2'b00, v} - 8'd52);
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

// ----- src/b64lw_ifs.sv -----
// Valid/ready channel interfaces for the raw byte input and the character output.
// No dependencies.
interface b64lw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64lw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ----- src/b64lw_fifo.sv -----
// Short register queue that decouples the grouping front from the character back end.
// Depends on nothing but its parameters.
module b64lw_fifo #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
    end
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store entry on push
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- src/b64lw_front.sv -----
// Front end: accepts bytes, gathers groups of three, tracks the line count and
// builds encoded groups for the queue. Depends on b64lw_pkg and b64lw_in_if.
module b64lw_front (
  input  logic              clk,
  input  logic              rst_n,
  b64lw_in_if.sink          in_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              q_full,
  output logic              q_push,
  output b64lw_pkg::job_t   q_job
);
  import b64lw_pkg::*;

  logic [7:0]  line_chars_r;
  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  pcnt_r, pcnt_nxt;
  logic [7:0]  lcnt_r, lcnt_nxt;
  logic [7:0]  lc_sum;
  logic [7:0]  b, b1, b2;
  logic        emit;
  logic        acc;

  // Take a byte whenever the queue has room for a group
  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign q_push      = acc && emit;

  assign b      = in_ch.data_byte;
  assign b1     = pend_r[15:8];
  assign b2     = pend_r[7:0];
  assign lc_sum = 8'(lcnt_r + 8'd4);

  // Classify the byte: hold it, close a padded group, or close a full group
  always_comb begin
    pend_nxt        = pend_r;
    pcnt_nxt        = pcnt_r;
    lcnt_nxt        = lcnt_r;
    emit            = 1'b0;
    q_job.chars[0]  = b64_sym(b[7:2]);
    q_job.chars[1]  = b64_sym({b[1:0], 4'b0000});
    q_job.chars[2]  = CHAR_PAD;
    q_job.chars[3]  = CHAR_PAD;
    q_job.crlf      = 1'b0;
    unique case (pcnt_r)
      2'd0: begin
        if (in_ch.last_byte) begin
          emit = 1'b1;
        end else begin
          pend_nxt = {b, 8'h00};
          pcnt_nxt = 2'd1;
        end
      end
      2'd1: begin
        q_job.chars[0] = b64_sym(b1[7:2]);
        q_job.chars[1] = b64_sym({b1[1:0], b[7:4]});
        q_job.chars[2] = b64_sym({b[3:0], 2'b00});
        if (in_ch.last_byte) begin
          emit = 1'b1;
        end else begin
          pend_nxt = {b1, b};
          pcnt_nxt = 2'd2;
        end
      end
      default: begin
        emit           = 1'b1;
        q_job.chars[0] = b64_sym(b1[7:2]);
        q_job.chars[1] = b64_sym({b1[1:0], b2[7:4]});
        q_job.chars[2] = b64_sym({b2[3:0], b[7:6]});
        q_job.chars[3] = b64_sym(b[5:0]);
        q_job.crlf     = (line_chars_r != 8'd0) && (lc_sum == line_chars_r);
        lcnt_nxt       = q_job.crlf ? 8'd0 : lc_sum;
        pend_nxt       = '0;
        pcnt_nxt       = 2'd0;
      end
    endcase
    // Drop all message state after the last byte
    if (in_ch.last_byte) begin
      pend_nxt = '0;
      pcnt_nxt = 2'd0;
      lcnt_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      pcnt_r <= 2'd0;
      lcnt_r <= 8'd0;
    end else if (acc) begin
      pend_r <= pend_nxt;
      pcnt_r <= pcnt_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

  // Line length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_chars_r <= LINE_CHARS_RST;
    end else if (cfg_we) begin
      line_chars_r <= cfg_wdata;
    end
  end

endmodule

// ----- src/b64lw_back.sv -----
// Back end: walks the head group of the queue and sends one character per cycle
// when not stalled, via an output register. Depends on b64lw_pkg, b64lw_out_if.
module b64lw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  b64lw_pkg::job_t   q_job,
  input  logic              q_empty,
  output logic              q_pop,
  b64lw_out_if.source       out_ch
);
  import b64lw_pkg::*;

  logic       valid_r;
  logic [7:0] char_r;
  logic       last_r;
  logic [2:0] idx_r;
  logic [7:0] cur_char;
  logic       cur_last;
  logic       load;

  assign out_ch.valid     = valid_r;
  assign out_ch.out_char  = char_r;
  assign out_ch.last_char = last_r;

  // Load when the output register is free or being taken
  assign load  = !q_empty && (!valid_r || out_ch.ready);
  assign q_pop = load && cur_last;

  // Select the character at the current position of the head group
  always_comb begin
    unique case (idx_r)
      IDX_CR:  cur_char = CHAR_CR;
      IDX_LF:  cur_char = CHAR_LF;
      default: cur_char = q_job.chars[idx_r[1:0]];
    endcase
    cur_last = q_job.crlf ? (idx_r == IDX_LF) : (idx_r == 3'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= cur_last ? 3'd0 : 3'(idx_r + 1'b1);
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= cur_char;
      last_r <= cur_last;
    end
  end

endmodule

// ----- src/base64_line_wrap_encoder.sv -----
// Top level of the streaming base64 encoder with CR LF line wrap.
// Depends on b64lw_pkg, b64lw_ifs, b64lw_front, b64lw_fifo and b64lw_back.
//
//  channel  | direction | payload                   | handshake
//  ---------+-----------+---------------------------+-------------------
//  in_ch    | in        | data_byte[7:0], last_byte | valid / ready
//  out_ch   | out       | out_char[7:0], last_char  | valid / ready
//  cfg      | in        | cfg_wdata[7:0] line_chars | cfg_we, no wait
//
// A byte is taken whenever the group queue has room; a full or padded group
// then leaves as 4 characters (6 if a full group adds CR LF), one per cycle
// while the output is ready, so the output port sets the sustained rate.
// Reset (rst_n low, synchronous) empties the queue and clears message state;
// the line length returns to 76. The input side stalls while the queue holds
// FIFO_DEPTH groups, the output side while it is empty.
module base64_line_wrap_encoder #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  b64lw_in_if.sink    in_ch,
  b64lw_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import b64lw_pkg::*;

  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  b64lw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64lw_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_job),
    .pop     (q_pop),
    .rd_data (head_job),
    .full    (q_full),
    .empty   (q_empty)
  );

  b64lw_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- src/b64lw_checker.sv -----
// Port-level checks for the base64 line-wrap encoder, bound to the top level.
// Depends on b64lw_pkg and base64_line_wrap_encoder.
module b64lw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);
  import b64lw_pkg::*;

  logic legal_char;

  // Alphabet, padding and line break only
  assign legal_char = ((out_char >= 8'h41) && (out_char <= 8'h5A)) ||
                      ((out_char >= 8'h61) && (out_char <= 8'h7A)) ||
                      ((out_char >= 8'h30) && (out_char <= 8'h39)) ||
                      (out_char == 8'h2B) || (out_char == 8'h2F) ||
                      (out_char == CHAR_PAD) || (out_char == CHAR_CR) ||
                      (out_char == CHAR_LF);

  // Hold a stalled character
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("output changed while stalled");

  a_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> legal_char)
    else $error("character outside base64 output set");

  // A line break ends its group and CR never does
  a_lf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char == CHAR_LF || out_char == CHAR_CR) |->
      (last_char == (out_char == CHAR_LF)))
    else $error("line break misplaced in group");

  a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_char == CHAR_CR) |=>
      out_valid && (out_char == CHAR_LF))
    else $error("CR not followed by LF");

endmodule

bind base64_line_wrap_encoder b64lw_checker u_b64lw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .last_char (out_ch.last_char)
);

// ----- test/base64_line_wrap_encoder_tb.sv -----
// Self-checking testbench for base64_line_wrap_encoder: directed table plus random messages.
// Depends on b64lw_pkg, b64lw_ifs and the encoder RTL; needs no files or arguments.
`timescale 1ns / 1ps

module base64_line_wrap_encoder_tb;
  import b64lw_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 32;
  localparam int RAND_PER_PHASE = 105;
  localparam int MAX_REPORTS    = 10;
  localparam int N_ROWS         = 30;

  // Standard alphabet, index 0 is 'A'
  localparam bit [0:63][7:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

  // One directed step: a byte (optionally with typed-in characters) or a line-length write
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  value;
    logic        lst;
    bit          typed;
    logic [2:0]  n_typed;
    logic [47:0] chars;
  } stim_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  b64lw_in_if  in_ch ();
  b64lw_out_if out_ch ();

  base64_line_wrap_encoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Encoder state mirrored by the testbench
  logic [7:0] line_len;
  logic [7:0] held_a;
  logic [7:0] held_b;
  logic [1:0] held_cnt;
  logic [7:0] line_cnt;

  enc_char_t enc_chars_q[$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        src_idle_pct;
  int        snk_idle_pct;

  stim_row_t directed_rows [N_ROWS] = '{
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 3'd4, {"AA==", 16'h0}},
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 3'd4, {"/w==", 16'h0}},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hFF, 1'b1, 1'b1, 3'd4, {"//8=", 16'h0}},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h00, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h00, 1'b1, 1'b1, 3'd4, {"AAAA", 16'h0}},
    // every full group ends a line, including the last of a message; padded ones do not
    '{ROW_CFG,  8'd4,  1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h4D, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h61, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h6E, 1'b1, 1'b1, 3'd6, {"TWFu", CHAR_CR, CHAR_LF}},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hFF, 1'b0, 1'b1, 3'd6, {"////", CHAR_CR, CHAR_LF}},
    '{ROW_BYTE, 8'h12, 1'b1, 1'b1, 3'd4, {"Eg==", 16'h0}},
    // two groups per line, then a length change while two bytes are held
    '{ROW_CFG,  8'd8,  1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hFB, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hEF, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hBE, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h02, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_CFG,  8'd0,  1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h03, 1'b1, 1'b0, 3'd0, 48'h0},
    // length that is not a multiple of four never breaks
    '{ROW_CFG,  8'd6,  1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h80, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h7F, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h55, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hAA, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'h01, 1'b0, 1'b0, 3'd0, 48'h0},
    '{ROW_BYTE, 8'hFE, 1'b1, 1'b0, 3'd0, 48'h0}
  };

  // Advance the mirrored encoder by one byte; queue its characters when asked
  function automatic void encode_byte(input logic [7:0] b, input logic lst,
                                      input bit queue_it);
    logic [7:0] grp [0:5];
    int         n;
    enc_char_t  e;
    n = 0;
    case (held_cnt)
      2'd0: begin
        if (lst) begin
          grp[0] = ALPHABET[b[7:2]];
          grp[1] = ALPHABET[{b[1:0], 4'b0000}];
          grp[2] = CHAR_PAD;
          grp[3] = CHAR_PAD;
          n = 4;
        end else begin
          held_a   = b;
          held_cnt = 2'd1;
        end
      end
      2'd1: begin
        if (lst) begin
          grp[0] = ALPHABET[held_a[7:2]];
          grp[1] = ALPHABET[{held_a[1:0], b[7:4]}];
          grp[2] = ALPHABET[{b[3:0], 2'b00}];
          grp[3] = CHAR_PAD;
          n = 4;
        end else begin
          held_b   = b;
          held_cnt = 2'd2;
        end
      end
      default: begin
        grp[0] = ALPHABET[held_a[7:2]];
        grp[1] = ALPHABET[{held_a[1:0], held_b[7:4]}];
        grp[2] = ALPHABET[{held_b[3:0], b[7:6]}];
        grp[3] = ALPHABET[b[5:0]];
        n = 4;
        line_cnt = line_cnt + 8'd4;
        if (line_len != 8'd0 && line_cnt == line_len) begin
          grp[4]   = CHAR_CR;
          grp[5]   = CHAR_LF;
          n        = 6;
          line_cnt = 8'd0;
        end
        held_cnt = 2'd0;
      end
    endcase
    // end of message clears the held count and the line count, not the line length
    if (lst) begin
      held_cnt = 2'd0;
      line_cnt = 8'd0;
    end
    if (queue_it) begin
      for (int i = 0; i < n; i++) begin
        e.ch   = grp[i];
        e.last = (i == n - 1);
        enc_chars_q.push_back(e);
      end
    end
  endfunction

  // Offer one byte after a random gap; predict at the edge that takes it
  task automatic push_byte(input logic [7:0] b, input logic lst, input bit typed,
                           input int n_typed, input logic [47:0] typed_chars);
    enc_char_t e;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_byte(b, lst, !typed);
    if (typed) begin
      for (int i = 0; i < n_typed; i++) begin
        e.ch   = typed_chars[47 - 8 * i -: 8];
        e.last = (i == n_typed - 1);
        enc_chars_q.push_back(e);
      end
    end
    @(negedge clk);
  endtask

  // Write the line length once the output has drained and the block has settled
  task automatic set_line_len(input logic [7:0] v);
    in_ch.valid <= 1'b0;
    while (enc_chars_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    line_len   = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_line_len();
    logic [7:0] v;
    case ($urandom_range(7))
      0:       v = 8'd0;
      1:       v = 8'd4;
      2:       v = 8'd255;
      3:       v = 8'd252;
      4:       v = LINE_CHARS_RST;
      5:       v = 8'($urandom_range(255));
      6:       v = {4'($urandom_range(1, 15)), 2'b00, 2'b00} >> 2;
      default: v = 8'd8;
    endcase
    return v;
  endfunction

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each accepted character with the oldest expectation
  always @(posedge clk) begin
    enc_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (enc_chars_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: char %h last %b with nothing expected",
                   $time, out_ch.out_char, out_ch.last_char);
      end else begin
        want = enc_chars_q.pop_front();
        if (out_ch.out_char !== want.ch || out_ch.last_char !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: char expected %h last %b, got %h last %b", $time,
                     want.ch, want.last, out_ch.out_char, out_ch.last_char);
        end
      end
    end
  end

  // Hard stop for a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    stim_row_t  row;
    int         msg_len;
    int         sent;
    logic [7:0] b;

    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'd0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    src_idle_pct    = 22;
    snk_idle_pct    = 63;
    line_len        = LINE_CHARS_RST;
    held_a          = 8'd0;
    held_b          = 8'd0;
    held_cnt        = 2'd0;
    line_cnt        = 8'd0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int r = 0; r < N_ROWS; r++) begin
      row = directed_rows[r];
      if (row.kind == ROW_CFG)
        set_line_len(row.value);
      else
        push_byte(row.value, row.lst, row.typed, int'(row.n_typed), row.chars);
    end

    // Random messages, one idle pattern per phase
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 22; snk_idle_pct = 63; end
        1:       begin src_idle_pct = 63; snk_idle_pct = 22; end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      endcase
      case (phase)
        0:       set_line_len(8'd255);
        1:       set_line_len(8'd4);
        default: set_line_len(LINE_CHARS_RST);
      endcase
      sent = 0;
      while (sent < RAND_PER_PHASE) begin
        if ($urandom_range(3) == 0)
          set_line_len(pick_line_len());
        msg_len = ($urandom_range(7) == 0) ? $urandom_range(40, 130)
                                           : $urandom_range(1, 14);
        for (int k = 0; k < msg_len; k++) begin
          if ($urandom_range(9) == 0)
            b = ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
          else
            b = 8'($urandom_range(255));
          push_byte(b, (k == msg_len - 1), 1'b0, 0, 48'h0);
        end
        sent += msg_len;
      end
    end

    // Drain and report
    in_ch.valid <= 1'b0;
    while (enc_chars_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
